### rtl/core/lsps_pkg.sv
// Types and constants shared by the LED status pattern sequencer.
package lsps_pkg;

    // Widths of the fixed fields
    localparam int unsigned ModeW   = 3;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned RegW    = 16;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned PhaseW  = 4;
    localparam int unsigned LedN    = 3;

    // Item function codes
    typedef enum logic {
        FUNC_SET  = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    // Display modes
    typedef enum logic [ModeW-1:0] {
        MODE_BOOT_JUMP   = 3'd0,
        MODE_IDLE        = 3'd1,
        MODE_WRITE       = 3'd2,
        MODE_VERIFY      = 3'd3,
        MODE_VERIFY_OK   = 3'd4,
        MODE_ERROR       = 3'd5,
        MODE_USB_MISSING = 3'd6,
        MODE_NONE        = 3'd7
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_IDLE_PERIOD   = 3'd0,
        CFG_WRITE_PERIOD  = 3'd1,
        CFG_VERIFY_PERIOD = 3'd2,
        CFG_FLASH_STEP    = 3'd3,
        CFG_BOOT_HOLD     = 3'd4,
        CFG_OK_HOLD       = 3'd5
    } t_cfg_idx;

    // Register reset values (ms)
    localparam logic [RegW-1:0] RST_IDLE_PERIOD   = 16'd500;
    localparam logic [RegW-1:0] RST_WRITE_PERIOD  = 16'd125;
    localparam logic [RegW-1:0] RST_VERIFY_PERIOD = 16'd1000;
    localparam logic [RegW-1:0] RST_FLASH_STEP    = 16'd100;
    localparam logic [RegW-1:0] RST_BOOT_HOLD     = 16'd1000;
    localparam logic [RegW-1:0] RST_OK_HOLD       = 16'd200;

    // Flash pattern lengths
    localparam logic [PhaseW-1:0] ERROR_PHASES = 4'd10;
    localparam logic [PhaseW-1:0] USB_PHASES   = 4'd12;

    // LED masks, bit k is LED k
    localparam logic [LedN-1:0] LEDS_OFF = 3'b000;
    localparam logic [LedN-1:0] LED0     = 3'b001;
    localparam logic [LedN-1:0] LED1     = 3'b010;
    localparam logic [LedN-1:0] LED2     = 3'b100;
    localparam logic [LedN-1:0] LEDS_ALL = 3'b111;

endpackage

### rtl/core/led_status_pattern_sequencer.sv
// Top level of the LED status pattern sequencer.
//
// Usage:
//  - Input channel (i_valid/o_ready) carries one beat per item: i_func selects
//    a mode set (i_mode_code, start time in i_now_ms) or a time tick (i_now_ms).
//  - Output channel (o_valid/i_ready) returns one beat per item: the three LED
//    levels after that item, in item order.
//  - Configuration channel (i_cfg_valid/o_cfg_ready) writes one 16-bit register
//    per beat; o_cfg_ready is always high, indexes past the last are ignored.
//    Write only while no item is in flight.
//  - Path: an accepted beat passes the input register, then the result register;
//    o_valid rises once the result register is loaded.
//  - Throughput: one item per cycle unless the receiver stalls; the elapsed-time
//    subtract and compare plus the phase update sit between the two registers.
//  - Reset (synchronous, active low): mode boot-jump, start time 0, phase 0,
//    LEDs off, registers to their defaults, both pipeline stages empty.
//  - When the receiver stalls the result register holds its beat; one more
//    item may sit in the input register, then o_ready drops.
module led_status_pattern_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [lsps_pkg::ModeW-1:0]    i_mode_code,
    input  logic [lsps_pkg::TimeW-1:0]    i_now_ms,
    // Result output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_led0_on,
    output logic                          o_led1_on,
    output logic                          o_led2_on,
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsps_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lsps_pkg::RegW-1:0]     i_cfg_data
);
    import lsps_pkg::*;

    // Configuration registers
    logic [RegW-1:0] r_idle_period, r_write_period, r_verify_period;
    logic [RegW-1:0] r_flash_step, r_boot_hold, r_ok_hold;

    // Input stage
    logic             r_in_valid;
    t_func            r_in_func;
    t_mode            r_in_mode;
    logic [TimeW-1:0] r_in_now;

    // Sequencer state
    t_mode             r_mode, n_mode;
    logic [TimeW-1:0]  r_start, n_start;
    logic [PhaseW-1:0] r_phase, n_phase;
    logic [LedN-1:0]   r_leds, n_leds;

    // Result stage
    logic            r_out_valid;
    logic [LedN-1:0] r_out_leds;

    logic             advance;
    logic             fire;
    logic [TimeW-1:0] elapsed;
    logic [PhaseW-1:0] phase_step;

    // Pipeline flow control
    assign advance     = !r_out_valid || i_ready;
    assign fire        = r_in_valid && advance;
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_period   <= RST_IDLE_PERIOD;
            r_write_period  <= RST_WRITE_PERIOD;
            r_verify_period <= RST_VERIFY_PERIOD;
            r_flash_step    <= RST_FLASH_STEP;
            r_boot_hold     <= RST_BOOT_HOLD;
            r_ok_hold       <= RST_OK_HOLD;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IDLE_PERIOD:   r_idle_period   <= i_cfg_data;
                CFG_WRITE_PERIOD:  r_write_period  <= i_cfg_data;
                CFG_VERIFY_PERIOD: r_verify_period <= i_cfg_data;
                CFG_FLASH_STEP:    r_flash_step    <= i_cfg_data;
                CFG_BOOT_HOLD:     r_boot_hold     <= i_cfg_data;
                CFG_OK_HOLD:       r_ok_hold       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_func <= t_func'(i_func);
            r_in_mode <= t_mode'(i_mode_code);
            r_in_now  <= i_now_ms;
        end
    end

    // Elapsed time, wrapping
    assign elapsed = r_in_now - r_start;

    // Next flash phase when a step is due (wraps per mode)
    always_comb begin
        phase_step = r_phase + 4'd1;
        if (r_mode == MODE_ERROR && r_phase >= ERROR_PHASES - 4'd1) begin
            phase_step = '0;
        end else if (r_mode == MODE_USB_MISSING && r_phase >= USB_PHASES - 4'd1) begin
            phase_step = '0;
        end
    end

    // Pattern update for one item
    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_phase = r_phase;
        n_leds  = r_leds;
        if (r_in_func == FUNC_SET) begin
            n_mode  = r_in_mode;
            n_start = r_in_now;
            n_phase = '0;
            case (r_in_mode)
                MODE_BOOT_JUMP: n_leds = LED0;
                MODE_VERIFY_OK: n_leds = LEDS_ALL;
                default:        n_leds = LEDS_OFF;
            endcase
        end else begin
            case (r_mode)
                MODE_BOOT_JUMP: begin
                    if (elapsed > {16'd0, r_boot_hold}) n_leds = LEDS_OFF;
                end
                MODE_VERIFY_OK: begin
                    if (elapsed > {16'd0, r_ok_hold}) n_leds = LEDS_OFF;
                end
                MODE_IDLE: begin
                    if (elapsed >= {16'd0, r_idle_period}) begin
                        n_start = r_in_now;
                        n_leds  = r_leds ^ LED0;
                    end
                end
                MODE_WRITE: begin
                    if (elapsed >= {16'd0, r_write_period}) begin
                        n_start = r_in_now;
                        n_leds  = r_leds ^ LED1;
                    end
                end
                MODE_VERIFY: begin
                    if (elapsed >= {16'd0, r_verify_period}) begin
                        n_start = r_in_now;
                        n_leds  = r_leds ^ LED2;
                    end
                end
                MODE_ERROR: begin
                    if (elapsed >= {16'd0, r_flash_step}) begin
                        n_start = r_in_now;
                        n_phase = phase_step;
                    end
                    // double flash: lit in phases 0 and 2
                    if (n_phase inside {4'd0, 4'd2}) n_leds = r_leds | LED2;
                    else                             n_leds = r_leds & ~LED2;
                end
                MODE_USB_MISSING: begin
                    if (elapsed >= {16'd0, r_flash_step}) begin
                        n_start = r_in_now;
                        n_phase = phase_step;
                    end
                    // triple flash: lit in phases 0, 2 and 4
                    if (n_phase inside {4'd0, 4'd2, 4'd4}) begin
                        n_leds = r_leds | LED1;
                    end else begin
                        n_leds = r_leds & ~LED1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BOOT_JUMP;
            r_start <= '0;
            r_phase <= '0;
            r_leds  <= LEDS_OFF;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_phase <= n_phase;
            r_leds  <= n_leds;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_out_leds <= n_leds;
    end

    assign o_valid   = r_out_valid;
    assign o_led0_on = r_out_leds[0];
    assign o_led1_on = r_out_leds[1];
    assign o_led2_on = r_out_leds[2];

    // Checks
    a_phase_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ERROR) |-> (r_phase < ERROR_PHASES))
        else $error("flash phase out of range in error mode");

    a_phase_usb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_USB_MISSING) |-> (r_phase < USB_PHASES))
        else $error("flash phase out of range in usb-missing mode");

    a_boot_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_BOOT_JUMP) |-> (r_leds == LED0 || r_leds == LEDS_OFF))
        else $error("boot-jump LEDs in unexpected pattern");

    a_ok_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_VERIFY_OK) |-> (r_leds == LEDS_ALL || r_leds == LEDS_OFF))
        else $error("verify-ok LEDs in unexpected pattern");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out_valid && r_out_leds == $past(n_leds)))
        else $error("result beat lost after stage fired");

endmodule
